/* src/bgr_pkg.sv */
// ----------------------------------------------------------------------------
// bgr_pkg
// types, constants and the pixel function of the bar graph rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package bgr_pkg;

  localparam logic       KIND_LOAD   = 1'b0;
  localparam logic       KIND_RENDER = 1'b1;

  localparam logic [5:0] HEIGHT_LIMIT = 6'd47;
  localparam logic [5:0] BOTTOM_ROW   = 6'd63;
  localparam logic [2:0] FIRST_PAGE   = 3'd2;
  localparam logic [2:0] LAST_PAGE    = 3'd7;
  localparam logic [6:0] LAST_COLUMN  = 7'd127;
  localparam logic [7:0] FULL_BYTE    = 8'hFF;

  localparam int         CFG_AW = 4;
  localparam logic [CFG_AW-1:0] REG_BAR_COUNT    = 4'h0;
  localparam logic [CFG_AW-1:0] REG_BAR_WIDTH    = 4'h4;
  localparam logic [CFG_AW-1:0] REG_BAR_GAP      = 4'h8;
  localparam logic [CFG_AW-1:0] REG_START_COLUMN = 4'hC;

  typedef struct packed {
    logic [7:0] bar_count;
    logic [6:0] bar_width;
    logic [6:0] bar_gap;
    logic [6:0] start_column;
  } bgr_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] page;
    logic [6:0] column;
    logic       draw;
    logic       last;
    logic [5:0] height;
  } bgr_stage_t;

  // rows 63-h to 63 lit; bit 0 is the top row of the page
  function automatic logic [7:0] column_byte(input logic [5:0] h, input logic [2:0] page);
    logic [5:0] top;
    logic [7:0] res;
    top = BOTTOM_ROW - h;
    if (h == 6'd0 || h > HEIGHT_LIMIT) begin
      res = 8'h00;
    end else if (top[5:3] > page) begin
      res = 8'h00;
    end else if (top[5:3] == page) begin
      res = FULL_BYTE << top[2:0];
    end else begin
      res = FULL_BYTE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/bgr_ifs.sv */
// ----------------------------------------------------------------------------
// bgr_ifs
// valid/ready channels for load/render words and display byte words
// ----------------------------------------------------------------------------
`default_nettype none

interface bgr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [6:0] bar_slot;
  logic [7:0] magnitude;

  modport source (output valid, kind, bar_slot, magnitude, input ready);
  modport sink   (input valid, kind, bar_slot, magnitude, output ready);
endinterface

interface bgr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] page;
  logic [6:0] column;
  logic [7:0] pixels;
  logic       frame_end;

  modport source (output valid, page, column, pixels, frame_end, input ready);
  modport sink   (input valid, page, column, pixels, frame_end, output ready);
endinterface

`default_nettype wire

/* src/bgr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bgr_cfg_regs
// apb register file: bar count, bar width, bar gap, start column
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bgr_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output bgr_pkg::bgr_cfg_t                cfg
);
  import bgr_pkg::*;

  bgr_cfg_t cfg_r;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bar_count    <= 8'd0;
      cfg_r.bar_width    <= 7'd1;
      cfg_r.bar_gap      <= 7'd0;
      cfg_r.start_column <= 7'd0;
    end else if (wr_en) begin
      case (paddr)
        REG_BAR_COUNT:    cfg_r.bar_count    <= pwdata[7:0];
        REG_BAR_WIDTH:    cfg_r.bar_width    <= pwdata[6:0];
        REG_BAR_GAP:      cfg_r.bar_gap      <= pwdata[6:0];
        REG_START_COLUMN: cfg_r.start_column <= pwdata[6:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_BAR_COUNT:    prdata = {24'd0, cfg_r.bar_count};
      REG_BAR_WIDTH:    prdata = {25'd0, cfg_r.bar_width};
      REG_BAR_GAP:      prdata = {25'd0, cfg_r.bar_gap};
      REG_START_COLUMN: prdata = {25'd0, cfg_r.start_column};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* src/bgr_scan.sv */
// ----------------------------------------------------------------------------
// bgr_scan
// height store, scan and bar counters, first register stage
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_scan #(
  parameter int MAX_BARS = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bgr_pkg::bgr_cfg_t   cfg,
  bgr_in_if.sink                   in_ch,
  input  wire logic                stage_take,
  output bgr_pkg::bgr_stage_t      stage
);
  import bgr_pkg::*;

  localparam int         AW      = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam logic [7:0] MAX_IDX = 8'(MAX_BARS);

  logic [5:0]    heights [MAX_BARS];
  logic [5:0]    rd_r;

  logic [2:0]    page_r, page_nxt;
  logic [6:0]    col_r, col_nxt;
  logic [7:0]    idx_r, idx_nxt;
  logic [7:0]    gp_r, gp_nxt;

  logic          a_v_r;
  logic [2:0]    a_page_r;
  logic [6:0]    a_col_r;
  logic          a_draw_r;
  logic          a_last_r;

  logic          accept, load_go, render_go, slot_ok, draw, last, at_start, wrap;
  logic [7:0]    eff_idx, eff_gp, group_w, slot_ext;
  logic [5:0]    clipped;

  assign in_ch.ready = !a_v_r || stage_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_go     = accept && (in_ch.kind == KIND_LOAD);
  assign render_go   = accept && (in_ch.kind == KIND_RENDER) && (cfg.bar_width != 7'd0);

  assign slot_ext = {1'b0, in_ch.bar_slot};
  assign slot_ok  = slot_ext < MAX_IDX;
  assign clipped  = (in_ch.magnitude > {2'b00, HEIGHT_LIMIT}) ? HEIGHT_LIMIT
                                                              : in_ch.magnitude[5:0];

  assign at_start = (col_r == cfg.start_column);
  assign eff_idx  = at_start ? 8'd0 : idx_r;
  assign eff_gp   = at_start ? 8'd0 : gp_r;
  assign group_w  = {1'b0, cfg.bar_width} + {1'b0, cfg.bar_gap};
  assign wrap     = ({1'b0, eff_gp} + 9'd1) >= {1'b0, group_w};

  assign draw = (col_r >= cfg.start_column) && (cfg.bar_count != 8'd0) &&
                (eff_idx < cfg.bar_count) && (eff_gp < {1'b0, cfg.bar_width}) &&
                (eff_idx < MAX_IDX);
  assign last = (page_r == LAST_PAGE) && (col_r == LAST_COLUMN);

  always_comb begin
    page_nxt = page_r;
    col_nxt  = col_r;
    idx_nxt  = idx_r;
    gp_nxt   = gp_r;
    if (render_go) begin
      if (wrap) begin
        gp_nxt  = 8'd0;
        idx_nxt = (eff_idx == 8'hFF) ? eff_idx : eff_idx + 8'd1;
      end else begin
        gp_nxt  = eff_gp + 8'd1;
        idx_nxt = eff_idx;
      end
      if (col_r == LAST_COLUMN) begin
        col_nxt  = 7'd0;
        page_nxt = (page_r == LAST_PAGE) ? FIRST_PAGE : page_r + 3'd1;
      end else begin
        col_nxt = col_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= FIRST_PAGE;
      col_r  <= 7'd0;
      idx_r  <= 8'd0;
      gp_r   <= 8'd0;
      a_v_r  <= 1'b0;
    end else begin
      page_r <= page_nxt;
      col_r  <= col_nxt;
      idx_r  <= idx_nxt;
      gp_r   <= gp_nxt;
      if (in_ch.ready) begin
        a_v_r <= render_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (render_go) begin
      a_page_r <= page_r;
      a_col_r  <= col_r;
      a_draw_r <= draw;
      a_last_r <= last;
    end
  end

  // height store
  always_ff @(posedge clk) begin
    if (load_go && slot_ok) begin
      heights[slot_ext[AW-1:0]] <= clipped;
    end
    if (render_go) begin
      rd_r <= heights[eff_idx[AW-1:0]];
    end
  end

  assign stage.valid  = a_v_r;
  assign stage.page   = a_page_r;
  assign stage.column = a_col_r;
  assign stage.draw   = a_draw_r;
  assign stage.last   = a_last_r;
  assign stage.height = rd_r;

`ifndef SYNTH
  a_reset_scan: assert property (@(posedge clk) !rst_n |=> (page_r == FIRST_PAGE && col_r == 7'd0))
    else $error("scan position not cleared by reset");
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    (page_r >= FIRST_PAGE && page_r <= LAST_PAGE))
    else $error("scan page out of range");
  a_load_no_word: assert property (@(posedge clk) disable iff (!rst_n) load_go |=> !a_v_r)
    else $error("load word entered the render stage");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && !stage_take) |=> (a_v_r && $stable(a_page_r) && $stable(a_col_r) &&
    $stable(a_draw_r) && $stable(a_last_r) && (!a_draw_r || $stable(rd_r))))
    else $error("stalled stage changed");
  a_frozen_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !render_go |=> ($stable(page_r) && $stable(col_r)))
    else $error("scan moved without a render word");
`endif

endmodule

`default_nettype wire

/* src/bgr_out_stage.sv */
// ----------------------------------------------------------------------------
// bgr_out_stage
// pixel byte build and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bgr_pkg::bgr_stage_t  stage,
  output logic                      stage_take,
  bgr_out_if.source                 out_ch
);
  import bgr_pkg::*;

  logic       o_v_r;
  logic [2:0] o_page_r;
  logic [6:0] o_col_r;
  logic [7:0] o_pix_r;
  logic       o_last_r;
  logic [7:0] pix_nxt;

  assign stage_take = !o_v_r || out_ch.ready;
  assign pix_nxt    = stage.draw ? column_byte(stage.height, stage.page) : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (stage_take) begin
      o_v_r <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && stage.valid) begin
      o_page_r <= stage.page;
      o_col_r  <= stage.column;
      o_pix_r  <= pix_nxt;
      o_last_r <= stage.last;
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.page      = o_page_r;
  assign out_ch.column    = o_col_r;
  assign out_ch.pixels    = o_pix_r;
  assign out_ch.frame_end = o_last_r;

endmodule

`default_nettype wire

/* src/bar_graph_page_rasterizer.sv */
// ----------------------------------------------------------------------------
// bar_graph_page_rasterizer
// spectrum bar graph rasterizer for a 128-column page-addressed display
//
// in_ch carries words: a load word stores a bar height (clipped to 47) in
// the height store, a render word asks for the next display byte in scan
// order, pages 2 to 7, columns 0 to 127, then wrapping. out_ch returns one
// word per render word with page, column, eight pixels and frame_end on
// the last byte of page 7. With bar width zero a render word is dropped.
// The apb port sets bar count, width, gap and start column; write it only
// while no words are in flight.
// A render word reads the height store when it is accepted; the byte is
// built from the stage register and held in the result register on out_ch.
// Throughput: one word per cycle while out_ch does not stall.
// Reset puts the scan at page 2, column 0 and the registers to their reset
// values; heights are undefined until loaded. When out_ch stalls the two
// stages fill and in_ch.ready drops until the receiver takes a word.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_graph_page_rasterizer #(
  parameter int MAX_BARS = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bgr_in_if.sink                           in_ch,
  bgr_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bgr_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import bgr_pkg::*;

  bgr_cfg_t   cfg;
  bgr_stage_t stage;
  logic       stage_take;

  bgr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bgr_scan #(
    .MAX_BARS (MAX_BARS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .stage_take (stage_take),
    .stage      (stage)
  );

  bgr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .stage_take (stage_take),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for bar_graph_page_rasterizer
//
// Drives load and render words with random gaps, stalls the display byte
// channel at random and once for a long stretch, and rewrites the four
// registers over apb between phases. A tracker class follows the height
// store, scan position and bar counters, queues one expected byte per render
// word not dropped, and compares every byte that comes out field by field.
// ----------------------------------------------------------------------------

import bgr_pkg::*;

typedef struct packed {
  logic [2:0] page;
  logic [6:0] column;
  logic [7:0] pixels;
  logic       frame_end;
} disp_byte_t;

class bar_raster_tracker;
  localparam int SLOTS = 128;

  logic [5:0] heights [SLOTS];
  bit         written [SLOTS];
  logic [2:0] scan_page;
  logic [6:0] scan_col;
  logic [7:0] bar_idx;
  logic [7:0] grp_pos;
  logic [7:0] bar_count;
  logic [6:0] bar_width;
  logic [6:0] bar_gap;
  logic [6:0] start_col;
  disp_byte_t pending_bytes [$];
  int errors, loads, renders, dropped, checked, frames;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      heights[i] = '0;
      written[i] = 1'b0;
    end
    scan_page = FIRST_PAGE;
    scan_col  = '0;
    bar_idx   = '0;
    grp_pos   = '0;
    bar_count = 8'd0;
    bar_width = 7'd1;
    bar_gap   = 7'd0;
    start_col = 7'd0;
  endfunction

  function void set_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
    case (addr)
      REG_BAR_COUNT:    bar_count = data[7:0];
      REG_BAR_WIDTH:    bar_width = data[6:0];
      REG_BAR_GAP:      bar_gap   = data[6:0];
      REG_START_COLUMN: start_col = data[6:0];
      default: ;
    endcase
  endfunction

  // eight rows of one page for a bar of height h, bit 0 on top
  function logic [7:0] pixel_byte(logic [5:0] h, logic [2:0] pg);
    int top, first, row;
    if (h == 0 || h > HEIGHT_LIMIT) return 8'h00;
    top   = int'(BOTTOM_ROW) - int'(h);
    first = int'(pg) * 8;
    if (top > first + 7) return 8'h00;
    row = (top > first) ? top : first;
    return FULL_BYTE << (row - first);
  endfunction

  // height slot that the next render word would read, if any
  function bit next_read(output int slot);
    logic [7:0] idx, gp;
    idx  = bar_idx;
    gp   = grp_pos;
    slot = 0;
    if (bar_width == 0) return 1'b0;
    if (scan_col == start_col) begin
      idx = '0;
      gp  = '0;
    end
    slot = int'(idx);
    return scan_col >= start_col && bar_count != 0 && idx < bar_count &&
           gp < bar_width && idx < SLOTS;
  endfunction

  function void take_word(logic k, logic [6:0] s, logic [7:0] m);
    int         gw;
    disp_byte_t b;
    if (k == KIND_LOAD) begin
      heights[s] = (m > HEIGHT_LIMIT) ? HEIGHT_LIMIT : m[5:0];
      written[s] = 1'b1;
      loads++;
      return;
    end
    renders++;
    if (bar_width == 0) begin
      dropped++;
      return;
    end
    gw = int'(bar_width) + int'(bar_gap);
    if (scan_col == start_col) begin
      bar_idx = '0;
      grp_pos = '0;
    end
    b.pixels = 8'h00;
    if (scan_col >= start_col && bar_count != 0 && bar_idx < bar_count &&
        grp_pos < bar_width && bar_idx < SLOTS)
      b.pixels = pixel_byte(heights[bar_idx[6:0]], scan_page);
    if (int'(grp_pos) + 1 >= gw) begin
      grp_pos = '0;
      if (bar_idx != 8'hFF) bar_idx++;
    end else begin
      grp_pos++;
    end
    b.page      = scan_page;
    b.column    = scan_col;
    b.frame_end = (scan_page == LAST_PAGE && scan_col == LAST_COLUMN);
    if (b.frame_end) frames++;
    pending_bytes.push_back(b);
    if (scan_col == LAST_COLUMN) begin
      scan_col  = '0;
      scan_page = (scan_page == LAST_PAGE) ? FIRST_PAGE : scan_page + 3'd1;
    end else begin
      scan_col++;
    end
  endfunction

  function void check_byte(logic [2:0] pg, logic [6:0] col, logic [7:0] px, logic fe);
    disp_byte_t e;
    if (pending_bytes.size() == 0) begin
      $error("unexpected display byte: page %0d column %0d pixels %h", pg, col, px);
      errors++;
      return;
    end
    e = pending_bytes.pop_front();
    checked++;
    if (pg !== e.page) begin
      $error("page: expected %0d, got %0d", e.page, pg);
      errors++;
    end
    if (col !== e.column) begin
      $error("column: expected %0d, got %0d", e.column, col);
      errors++;
    end
    if (px !== e.pixels) begin
      $error("pixels: expected %h, got %h", e.pixels, px);
      errors++;
    end
    if (fe !== e.frame_end) begin
      $error("frame_end: expected %0d, got %0d", e.frame_end, fe);
      errors++;
    end
  endfunction
endclass

module tb;
  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  bit                quiet;
  bit                long_hold_req;
  int                hold_left;
  int                settings;
  bar_raster_tracker sb;

  bgr_in_if  in_if ();
  bgr_out_if out_if ();

  bar_graph_page_rasterizer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // byte receiver: random stalls, one long hold on request
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_byte(out_if.page, out_if.column, out_if.pixels, out_if.frame_end);
  end

  task automatic send_word(input logic k, input logic [6:0] s, input logic [7:0] m);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.bar_slot  <= s;
    in_if.magnitude <= m;
    do @(posedge clk); while (!in_if.ready);
    sb.take_word(k, s, m);
  endtask

  // a render word, preceded by a load if it would read an unwritten height
  task automatic send_render();
    int slot;
    if (sb.next_read(slot) && !sb.written[slot])
      send_word(KIND_LOAD, 7'(slot), 8'($urandom_range(255)));
    send_word(KIND_RENDER, 7'($urandom_range(127)), 8'($urandom_range(255)));
  endtask

  task automatic run_words(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70)
        send_render();
      else if ($urandom_range(1) == 1)
        send_word(KIND_LOAD, 7'($urandom_range(127)), 8'($urandom_range(255)));
      else
        send_word(KIND_LOAD, 7'($urandom_range(127)), 8'($urandom_range(HEIGHT_LIMIT)));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int cnt, input int wid, input int gap, input int strt);
    write_reg(REG_BAR_COUNT, cnt);
    write_reg(REG_BAR_WIDTH, wid);
    write_reg(REG_BAR_GAP, gap);
    write_reg(REG_START_COLUMN, strt);
    settings++;
  endtask

  initial begin
    int cnt, wid, gap, strt;
    sb              = new();
    settings        = 0;
    quiet           = 1'b0;
    long_hold_req   = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_LOAD;
    in_if.bar_slot  = '0;
    in_if.magnitude = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: no bars, so a blank byte
    send_render();
    send_word(KIND_LOAD, 7'd0, 8'd255);
    send_word(KIND_LOAD, 7'd1, 8'd47);
    send_word(KIND_LOAD, 7'd2, 8'd46);
    send_word(KIND_LOAD, 7'd3, 8'd0);
    send_word(KIND_LOAD, 7'd4, 8'd40);
    send_word(KIND_LOAD, 7'd127, 8'd48);
    send_word(KIND_LOAD, 7'd5, 8'd1);
    drain();
    configure(8, 1, 0, 0);
    repeat (7) send_render();
    drain();
    // zero width: render words dropped, scan holds
    configure(8, 0, 0, 0);
    repeat (2) send_render();
    drain();
    // columns before the start column stay blank
    configure(3, 2, 3, 20);
    repeat (4) send_render();
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin cnt = 128; wid = 1;   gap = 0;   strt = 0;   end
        1: begin cnt = 16;  wid = 7;   gap = 1;   strt = 0;   end
        2: begin cnt = 0;   wid = 3;   gap = 2;   strt = 10;  end
        3: begin cnt = 128; wid = 127; gap = 127; strt = 127; end
        4: begin cnt = 5;   wid = 0;   gap = 127; strt = 64;  end
        default: begin
          cnt  = $urandom_range(128);
          wid  = ($urandom_range(3) == 0) ? $urandom_range(127, 1) : $urandom_range(8, 1);
          gap  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(4);
          strt = ($urandom_range(1) == 0) ? $urandom_range(127) : $urandom_range(8);
        end
      endcase
      configure(cnt, wid, gap, strt);
      if (ph == 1) long_hold_req = 1'b1;
      quiet = (ph == 2);
      run_words((wid == 0) ? 60 : 190);
      quiet = 1'b0;
      drain();
    end

    $display("%0d load words, %0d render words (%0d dropped at zero width), %0d settings",
             sb.loads, sb.renders, sb.dropped, settings);
    $display("%0d display bytes checked across %0d full frames", sb.checked, sb.frames);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* files.f */
src/bgr_pkg.sv
src/bgr_ifs.sv
src/bgr_cfg_regs.sv
src/bgr_scan.sv
src/bgr_out_stage.sv
src/bar_graph_page_rasterizer.sv
tb/tb.sv
